// ===== rtl/core/multi_led_blink_controller_defines.svh =====
// assertion macros for the led blink controller
`ifndef MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH
`define MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define MLBC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mlbc assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define MLBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mlbc assertion failed");

`endif

// ===== rtl/core/mlbc_pkg.sv =====
`timescale 1ns / 1ps

package mlbc_pkg;

   localparam logic [7:0]  COUNT_LIMIT = 8'd255;
   localparam logic [10:0] PERIOD_MAX  = 11'd1024;
   localparam logic [10:0] PERIOD_MIN  = 11'd4;
   localparam logic [3:0]  CFG_RESET   = 4'd8;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_BLINK = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_HOLD  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  channel;
      logic [15:0] blink_count;
      logic [15:0] half_period;
   } req_item_type;

   typedef struct packed {
      logic [7:0] lights;
      logic [7:0] active;
   } rsp_item_type;

   // per-channel update request, already qualified by item acceptance
   typedef struct packed {
      logic        tick;
      logic        stop;
      logic        blink;
      logic [15:0] count;
      logic [10:0] period;
   } lane_ctrl_type;

endpackage

// ===== rtl/core/multi_led_blink_controller.sv =====
// an accepted item waits in the input register; its result is registered in the output register when applied
// throughput: one item per cycle while the result is not stalled; a stalled
//    result blocks the next item only once the input register is full
// reset: synchronous, clears every channel and sets the channel limit csr_ff to 8
`timescale 1ns / 1ps
`include "multi_led_blink_controller_defines.svh"

module multi_led_blink_controller #(
   parameter int unsigned MAX_CHANNELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mlbc_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mlbc_pkg::rsp_item_type rsp_item,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data
);

   logic                   s1_valid_ff, s1_valid_in;
   mlbc_pkg::req_item_type s1_item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   mlbc_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic [3:0]             csr_ff;
   logic                   advance;
   logic                   apply;
   logic                   is_tick, is_stop, is_blink;
   logic [10:0]            period;
   logic [MAX_CHANNELS-1:0] lit_vec;
   logic [MAX_CHANNELS-1:0] busy_vec;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign apply     = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_comb begin
      is_tick  = 1'b0;
      is_stop  = 1'b0;
      is_blink = 1'b0;
      unique case (mlbc_pkg::mode_type'(s1_item_ff.mode))
         mlbc_pkg::MODE_TICK:  is_tick  = apply;
         mlbc_pkg::MODE_BLINK: is_blink = apply;
         mlbc_pkg::MODE_STOP:  is_stop  = apply;
         mlbc_pkg::MODE_HOLD:  ;
      endcase
   end

   always_comb begin
      priority if (s1_item_ff.half_period > 16'(mlbc_pkg::PERIOD_MAX)) begin
         period = mlbc_pkg::PERIOD_MAX;
      end else if (s1_item_ff.half_period < 16'(mlbc_pkg::PERIOD_MIN)) begin
         period = mlbc_pkg::PERIOD_MIN;
      end else begin
         period = s1_item_ff.half_period[10:0];
      end
   end

   for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
      mlbc_pkg::lane_ctrl_type ctrl;
      always_comb begin
         ctrl.tick   = is_tick;
         ctrl.stop   = is_stop;
         ctrl.blink  = is_blink && (int'(s1_item_ff.channel) == i) && (i < int'(csr_ff));
         ctrl.count  = s1_item_ff.blink_count;
         ctrl.period = period;
      end
      mlbc_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .lit_next  (lit_vec[i]),
         .busy_next (busy_vec[i])
      );
   end

   // bitmaps show channels 0..7 only
   for (genvar k = 0; k < 8; k++) begin : g_map
      if (k < MAX_CHANNELS) begin : g_used
         assign rsp_item_in.lights[k] = lit_vec[k];
         assign rsp_item_in.active[k] = busy_vec[k];
      end else begin : g_none
         assign rsp_item_in.lights[k] = 1'b0;
         assign rsp_item_in.active[k] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         csr_ff       <= mlbc_pkg::CFG_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_item_ff <= req_item;
      end
      if (apply) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `MLBC_ASSERT_NEXT(a_apply_gives_result, apply, rsp_valid_ff)
   `MLBC_ASSERT_NOW(a_stall_only_when_full, req_stall, s1_valid_ff)
   `MLBC_ASSERT_NOW(a_lit_is_active, rsp_valid_ff, (rsp_item_ff.lights & ~rsp_item_ff.active) == 8'd0)
   `MLBC_ASSERT_NEXT(a_stop_result_dark, is_stop, rsp_item_ff.active == 8'd0)

endmodule

// ===== rtl/core/mlbc_lane.sv =====
`timescale 1ns / 1ps
`include "multi_led_blink_controller_defines.svh"

module mlbc_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  mlbc_pkg::lane_ctrl_type ctrl,
   output logic                   lit_next,
   output logic                   busy_next
);

   logic [7:0]  pending_ff, pending_in;
   logic [10:0] period_ff, period_in;
   logic [10:0] ticks_ff, ticks_in;
   logic        lit_ff, lit_in;
   logic [8:0]  sum;
   logic [7:0]  total;
   logic [7:0]  pending_dec;

   always_comb begin
      sum         = {1'b0, pending_ff} + {1'b0, ctrl.count[7:0]};
      total       = ((ctrl.count[15:8] != 8'd0) || sum[8]) ? mlbc_pkg::COUNT_LIMIT : sum[7:0];
      pending_dec = pending_ff - 8'd1;
      pending_in  = pending_ff;
      period_in   = period_ff;
      ticks_in    = ticks_ff;
      lit_in      = lit_ff;
      priority if (ctrl.stop) begin
         pending_in = '0;
         period_in  = '0;
         ticks_in   = '0;
         lit_in     = 1'b0;
      end else if (ctrl.tick) begin
         if (pending_ff != 8'd0) begin
            if (ticks_ff > 11'd1) begin
               ticks_in = ticks_ff - 11'd1;
            end else if (lit_ff) begin
               lit_in   = 1'b0;
               ticks_in = period_ff;
            end else begin
               pending_in = pending_dec;
               if (pending_dec != 8'd0) begin
                  lit_in   = 1'b1;
                  ticks_in = period_ff;
               end else begin
                  ticks_in = '0;
               end
            end
         end
      end else if (ctrl.blink) begin
         if (ctrl.count == 16'd0) begin
            // soft stop: let the current blink finish
            if (pending_ff > 8'd1) begin
               pending_in = 8'd1;
            end
         end else begin
            period_in  = ctrl.period;
            pending_in = total;
            if (pending_ff == 8'd0) begin
               lit_in   = 1'b1;
               ticks_in = ctrl.period;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         period_ff  <= '0;
         ticks_ff   <= '0;
         lit_ff     <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         period_ff  <= period_in;
         ticks_ff   <= ticks_in;
         lit_ff     <= lit_in;
      end
   end

   assign lit_next  = lit_in;
   assign busy_next = (pending_in != 8'd0);

   `MLBC_ASSERT_NOW(a_lit_needs_pending, lit_ff, pending_ff != 8'd0)
   `MLBC_ASSERT_NOW(a_ticks_bounded, 1'b1, ticks_ff <= mlbc_pkg::PERIOD_MAX)
   `MLBC_ASSERT_NEXT(a_stop_clears, ctrl.stop, (pending_ff == 8'd0) && !lit_ff)

endmodule

// ===== tb/tb_multi_led_blink_controller.sv =====
`timescale 1ns / 1ps

module tb_multi_led_blink_controller;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   mlbc_pkg::req_item_type req_item;
   logic rsp_valid;
   logic rsp_stall;
   mlbc_pkg::rsp_item_type rsp_item;
   logic csr_wr_en;
   logic [3:0] csr_wr_data;

   multi_led_blink_controller DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // blinker state as the block should hold it
   logic [7:0]  lane_pending [8] = '{default: '0};
   logic [10:0] lane_period [8] = '{default: '0};
   logic [10:0] lane_left [8] = '{default: '0};
   logic        lane_lit [8] = '{default: '0};
   logic [3:0]  lane_limit = mlbc_pkg::CFG_RESET;

   mlbc_pkg::rsp_item_type expected_status [$];
   int unsigned mismatch_count = 0;

   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;
   int unsigned rsp_hold_len = 0;

   function automatic mlbc_pkg::rsp_item_type advance_blinker(
      input mlbc_pkg::req_item_type it);
      int total;
      logic [10:0] period;
      logic [7:0] prior;
      mlbc_pkg::rsp_item_type status;
      unique case (it.mode)
         mlbc_pkg::MODE_TICK: begin
            for (int i = 0; i < 8; i++) begin
               if (lane_pending[i] != 0) begin
                  if (lane_left[i] > 1) begin
                     lane_left[i] = lane_left[i] - 1'b1;
                  end else if (lane_lit[i]) begin
                     lane_lit[i] = 1'b0;
                     lane_left[i] = lane_period[i];
                  end else begin
                     lane_pending[i] = lane_pending[i] - 1'b1;
                     if (lane_pending[i] != 0) begin
                        lane_lit[i] = 1'b1;
                        lane_left[i] = lane_period[i];
                     end else begin
                        lane_left[i] = '0;
                     end
                  end
               end
            end
         end
         mlbc_pkg::MODE_BLINK: begin
            if ({1'b0, it.channel} < lane_limit) begin
               prior = lane_pending[it.channel];
               if (it.blink_count == 0) begin
                  if (prior > 1) lane_pending[it.channel] = 8'd1;
               end else begin
                  total = int'(prior) + int'(it.blink_count);
                  if (total > int'(mlbc_pkg::COUNT_LIMIT)) total = int'(mlbc_pkg::COUNT_LIMIT);
                  if (it.half_period > mlbc_pkg::PERIOD_MAX) period = mlbc_pkg::PERIOD_MAX;
                  else if (it.half_period < mlbc_pkg::PERIOD_MIN) period = mlbc_pkg::PERIOD_MIN;
                  else period = it.half_period[10:0];
                  lane_period[it.channel] = period;
                  lane_pending[it.channel] = total[7:0];
                  if (prior == 0) begin
                     lane_lit[it.channel] = 1'b1;
                     lane_left[it.channel] = period;
                  end
               end
            end
         end
         mlbc_pkg::MODE_STOP: begin
            for (int i = 0; i < 8; i++) begin
               lane_pending[i] = '0;
               lane_period[i] = '0;
               lane_left[i] = '0;
               lane_lit[i] = 1'b0;
            end
         end
         mlbc_pkg::MODE_HOLD: ;
      endcase
      for (int i = 0; i < 8; i++) begin
         status.lights[i] = lane_lit[i];
         status.active[i] = (lane_pending[i] != 0);
      end
      return status;
   endfunction

   function automatic mlbc_pkg::req_item_type req(input logic [1:0] mode,
                                                  input logic [2:0] ch,
                                                  input logic [15:0] count,
                                                  input logic [15:0] half);
      mlbc_pkg::req_item_type it;
      it.mode = mode;
      it.channel = ch;
      it.blink_count = count;
      it.half_period = half;
      return it;
   endfunction

   function automatic mlbc_pkg::req_item_type random_request();
      mlbc_pkg::req_item_type it;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 58) it.mode = mlbc_pkg::MODE_TICK;
      else if (r < 92) it.mode = mlbc_pkg::MODE_BLINK;
      else if (r < 94) it.mode = mlbc_pkg::MODE_STOP;
      else it.mode = mlbc_pkg::MODE_HOLD;
      it.channel = 3'($urandom_range(0, 7));
      r = $urandom_range(0, 19);
      if (r == 0) it.blink_count = '0;
      else if (r < 15) it.blink_count = 16'($urandom_range(1, 4));
      else if (r < 18) it.blink_count = 16'($urandom_range(5, 300));
      else it.blink_count = 16'($urandom);
      r = $urandom_range(0, 19);
      if (r < 14) it.half_period = 16'($urandom_range(0, 10));
      else if (r < 17) it.half_period = 16'($urandom_range(11, 40));
      else it.half_period = 16'($urandom);
      return it;
   endfunction

   // entered and left at a falling edge
   task automatic send_req(input mlbc_pkg::req_item_type it);
      int unsigned gap;
      gap = req_gaps ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      expected_status.push_back(advance_blinker(it));
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_channel_limit(input logic [3:0] value);
      drain_pipeline();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      lane_limit = value;
   endtask

   task automatic test_directed_blinks();
      send_req(req(mlbc_pkg::MODE_HOLD, 3'd0, 16'd0, 16'd0));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd0, 16'd1, 16'd0));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd7, 16'hFFFF, 16'hFFFF));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd3, 16'd2, 16'd3));
      // soft stop with two pending, then with one, then on an idle channel
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd3, 16'd0, 16'd9));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd3, 16'd0, 16'd9));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd5, 16'd0, 16'd9));
      // busy channel takes the count and new period, keeps its countdown
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd0, 16'd3, 16'd1025));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd1, 16'd1, 16'd4));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd2, 16'd1, 16'd1024));
      repeat (9) send_req(req(mlbc_pkg::MODE_TICK, 3'd7, 16'hFFFF, 16'hFFFF));
      send_req(req(mlbc_pkg::MODE_HOLD, 3'd7, 16'hFFFF, 16'hFFFF));
      send_req(req(mlbc_pkg::MODE_STOP, 3'd0, 16'd1, 16'd4));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd6, 16'hAAAA, 16'h5555));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd4, 16'h5555, 16'hAAAA));
      send_req(req(mlbc_pkg::MODE_STOP, 3'd0, 16'd0, 16'd0));
   endtask

   task automatic test_channel_limit();
      write_channel_limit(4'd0);
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd0, 16'd2, 16'd4));
      send_req(req(mlbc_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0));
      write_channel_limit(4'd15);
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd7, 16'd2, 16'd4));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd5, 16'd3, 16'd5));
      write_channel_limit(4'd1);
      // channels above the limit keep blinking but take no commands
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd7, 16'd0, 16'd4));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd1, 16'd2, 16'd4));
      send_req(req(mlbc_pkg::MODE_BLINK, 3'd0, 16'd1, 16'd6));
      repeat (20) send_req(req(mlbc_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0));
      send_req(req(mlbc_pkg::MODE_STOP, 3'd0, 16'd0, 16'd0));
      write_channel_limit(mlbc_pkg::CFG_RESET);
   endtask

   task automatic test_input_backpressure();
      req_gaps = 1'b0;
      rsp_hold_len = 80;
      repeat (40) send_req(random_request());
      drain_pipeline();
      req_gaps = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [3:0] limits [8] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd2, 4'd7, 4'd8};
      for (int k = 0; k < 8; k++) begin
         write_channel_limit(limits[k]);
         req_gaps = (k % 3 != 2);
         rsp_gaps = (k % 4 != 1);
         repeat (240) send_req(random_request());
      end
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   // receiver: random hold-off per item, plus one long hold when asked
   initial begin
      int unsigned n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            n = rsp_hold_len;
            rsp_hold_len = 0;
         end else begin
            n = rsp_gaps ? $urandom_range(0, 17) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      mlbc_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected item, expected none actual %h", $time, rsp_item);
            mismatch_count++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_item.lights !== want.lights) begin
               $display("%0t: lights mismatch, expected %h actual %h",
                        $time, want.lights, rsp_item.lights);
               mismatch_count++;
            end
            if (rsp_item.active !== want.active) begin
               $display("%0t: active mismatch, expected %h actual %h",
                        $time, want.active, rsp_item.active);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_blinks();
      test_channel_limit();
      test_input_backpressure();
      test_random_traffic();
      drain_pipeline();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("%0t: timeout, %0d items still expected", $time, expected_status.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== multi_led_blink_controller.f =====
+incdir+rtl/core
rtl/core/mlbc_pkg.sv
rtl/core/mlbc_lane.sv
rtl/core/multi_led_blink_controller.sv
tb/tb_multi_led_blink_controller.sv
